// File: rtl/mor_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mor_pkg
// Shared types and constants for the mode overlap ratio block.
// ============================================================================
package mor_pkg;

    localparam int CELL_COUNT_LOG2_DEF = 20;

    localparam int FIELD_W   = 16;
    localparam int TERM_W    = 2 * FIELD_W + 1;
    localparam int RATIO_W   = 16;
    localparam int CNT_W     = 4;
    localparam int STEP_W    = 3;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(8);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(15);

    localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_DRAIN,
        ST_MAG,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_LOAD
    } mor_state_t;

    typedef struct packed {
        logic              take;       // item accepted this cycle
        logic              mag_load;   // take magnitudes, clear sums
        logic              mul_en;     // issue one partial product
        logic [STEP_W-1:0] mul_step;
        logic              add_en;     // fold previous partial product
        logic              chk_en;
        logic              div_en;
        logic              div_first;
        logic              out_load;
    } mor_cmd_t;

    typedef struct packed {
        logic out_busy;
    } mor_status_t;

endpackage

// File: rtl/mor_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// mor_ctrl
// Sequencer: accumulation, drain, magnitude, multiply, check, divide, result load.
// ============================================================================
module mor_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 last_cell,
    output logic                 in_ready,
    input  mor_pkg::mor_status_t status,
    output mor_pkg::mor_cmd_t    cmd
);
    import mor_pkg::*;

    mor_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_ACC:
            begin
                if (in_valid && last_cell)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_MAG;
            ST_MAG:
            begin
                state_next = ST_MUL;
                cnt_next   = '0;
            end
            ST_MUL:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = ST_CHK;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_CHK:
            begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                    state_next = ST_LOAD;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_LOAD:
            begin
                if (!status.out_busy)
                    state_next = ST_ACC;
            end
            default:
                state_next = ST_ACC;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_ACC:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_MAG:
                cmd.mag_load = 1'b1;
            ST_MUL:
            begin
                cmd.mul_en   = !cnt_reg[CNT_W-1];
                cmd.mul_step = cnt_reg[STEP_W-1:0];
                cmd.add_en   = (cnt_reg != '0);
            end
            ST_CHK:
                cmd.chk_en = 1'b1;
            ST_DIV:
            begin
                cmd.div_en    = 1'b1;
                cmd.div_first = (cnt_reg == '0);
            end
            ST_LOAD:
                cmd.out_load = !status.out_busy;
            default:
                cmd = '0;
        endcase
    end

endmodule

// File: rtl/mor_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// mor_datapath
// Cross-product accumulators, shared partial-product multiplier, restoring
// divider and output register.
// ============================================================================
module mor_datapath
#(
    parameter int CELL_COUNT_LOG2 = mor_pkg::CELL_COUNT_LOG2_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [mor_pkg::FIELD_W-1:0] e_x_first,
    input  logic signed [mor_pkg::FIELD_W-1:0] e_y_first,
    input  logic signed [mor_pkg::FIELD_W-1:0] h_x_first,
    input  logic signed [mor_pkg::FIELD_W-1:0] h_y_first,
    input  logic signed [mor_pkg::FIELD_W-1:0] e_x_second,
    input  logic signed [mor_pkg::FIELD_W-1:0] e_y_second,
    input  logic signed [mor_pkg::FIELD_W-1:0] h_x_second,
    input  logic signed [mor_pkg::FIELD_W-1:0] h_y_second,
    input  mor_pkg::mor_cmd_t                  cmd,
    output mor_pkg::mor_status_t               status,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [mor_pkg::RATIO_W-1:0]        overlap_ratio,
    output logic                               zero_denominator
);
    import mor_pkg::*;

    localparam int ACC_W  = CELL_COUNT_LOG2 + 34;
    localparam int HALF_W = (ACC_W + 1) / 2;
    localparam int PP_W   = 2 * HALF_W;
    localparam int PROD_W = 2 * ACC_W;

    // ---- stage 1: per-cell terms ----
    logic signed [2*FIELD_W-1:0] p_ex1_hy2, p_hx2_ey1, p_ex2_hy1, p_hx1_ey2;
    logic signed [2*FIELD_W-1:0] p_ex1_hy1, p_hx1_ey1, p_ex2_hy2, p_hx2_ey2;
    logic [TERM_W-1:0] t_fs, t_sf, t_s1, t_s2;

    logic [TERM_W-1:0] t_fs_reg, t_sf_reg, t_s1_reg, t_s2_reg;
    logic              t_valid_reg;

    always_comb
    begin
        p_ex1_hy2 = e_x_first  * h_y_second;
        p_hx2_ey1 = h_x_second * e_y_first;
        p_ex2_hy1 = e_x_second * h_y_first;
        p_hx1_ey2 = h_x_first  * e_y_second;
        p_ex1_hy1 = e_x_first  * h_y_first;
        p_hx1_ey1 = h_x_first  * e_y_first;
        p_ex2_hy2 = e_x_second * h_y_second;
        p_hx2_ey2 = h_x_second * e_y_second;
        t_fs = {p_ex1_hy2[2*FIELD_W-1], p_ex1_hy2} - {p_hx2_ey1[2*FIELD_W-1], p_hx2_ey1};
        t_sf = {p_ex2_hy1[2*FIELD_W-1], p_ex2_hy1} - {p_hx1_ey2[2*FIELD_W-1], p_hx1_ey2};
        t_s1 = {p_ex1_hy1[2*FIELD_W-1], p_ex1_hy1} - {p_hx1_ey1[2*FIELD_W-1], p_hx1_ey1};
        t_s2 = {p_ex2_hy2[2*FIELD_W-1], p_ex2_hy2} - {p_hx2_ey2[2*FIELD_W-1], p_hx2_ey2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_valid_reg <= 1'b0;
        else
            t_valid_reg <= cmd.take;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            t_fs_reg <= t_fs;
            t_sf_reg <= t_sf;
            t_s1_reg <= t_s1;
            t_s2_reg <= t_s2;
        end
    end

    // ---- stage 2: accumulators, wrap modulo 2^ACC_W ----
    logic [ACC_W-1:0] acc_fs_reg, acc_sf_reg, acc_s1_reg, acc_s2_reg;

    function automatic logic [ACC_W-1:0] sext(input logic [TERM_W-1:0] t);
        return {{(ACC_W-TERM_W){t[TERM_W-1]}}, t};
    endfunction

    function automatic logic [ACC_W-1:0] mag(input logic [ACC_W-1:0] a);
        return a[ACC_W-1] ? (~a + 1'b1) : a;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_fs_reg <= '0;
            acc_sf_reg <= '0;
            acc_s1_reg <= '0;
            acc_s2_reg <= '0;
        end
        else if (cmd.mag_load)
        begin
            acc_fs_reg <= '0;
            acc_sf_reg <= '0;
            acc_s1_reg <= '0;
            acc_s2_reg <= '0;
        end
        else if (t_valid_reg)
        begin
            acc_fs_reg <= acc_fs_reg + sext(t_fs_reg);
            acc_sf_reg <= acc_sf_reg + sext(t_sf_reg);
            acc_s1_reg <= acc_s1_reg + sext(t_s1_reg);
            acc_s2_reg <= acc_s2_reg + sext(t_s2_reg);
        end
    end

    // ---- magnitudes ----
    logic [ACC_W-1:0] mag_fs_reg, mag_sf_reg, mag_s1_reg, mag_s2_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mag_load)
        begin
            mag_fs_reg <= mag(acc_fs_reg);
            mag_sf_reg <= mag(acc_sf_reg);
            mag_s1_reg <= mag(acc_s1_reg);
            mag_s2_reg <= mag(acc_s2_reg);
        end
    end

    // ---- shared half-width multiplier, four partial products per product ----
    logic [ACC_W-1:0]  op_a, op_b;
    logic [HALF_W-1:0] half_a, half_b;
    logic [PP_W-1:0]   pp_reg;
    logic [STEP_W-1:0] step_reg;
    logic [PROD_W-1:0] num_reg, den_reg;
    logic [PROD_W-1:0] pp_shifted;

    always_comb
    begin
        op_a   = cmd.mul_step[2] ? mag_s1_reg : mag_fs_reg;
        op_b   = cmd.mul_step[2] ? mag_s2_reg : mag_sf_reg;
        half_a = cmd.mul_step[1] ? HALF_W'(op_a >> HALF_W) : op_a[HALF_W-1:0];
        half_b = cmd.mul_step[0] ? HALF_W'(op_b >> HALF_W) : op_b[HALF_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            pp_reg   <= half_a * half_b;
            step_reg <= cmd.mul_step;
        end
    end

    always_comb
    begin
        case ({step_reg[1], step_reg[0]})
            2'b00:   pp_shifted = PROD_W'(pp_reg);
            2'b11:   pp_shifted = PROD_W'(pp_reg) << (2 * HALF_W);
            default: pp_shifted = PROD_W'(pp_reg) << HALF_W;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mag_load)
        begin
            num_reg <= '0;
            den_reg <= '0;
        end
        else if (cmd.add_en)
        begin
            if (step_reg[2])
                den_reg <= den_reg + pp_shifted;
            else
                num_reg <= num_reg + pp_shifted;
        end
    end

    // ---- range check and restoring division ----
    logic               zero_reg, sat_reg;
    logic [PROD_W-1:0]  rem_reg;
    logic [RATIO_W-1:0] quo_reg;
    logic [PROD_W:0]    cand;
    logic               q_bit;

    always_ff @(posedge clk)
    begin
        if (cmd.chk_en)
        begin
            zero_reg <= (den_reg == '0);
            sat_reg  <= ({1'b0, num_reg} >= {den_reg, 1'b0});
        end
    end

    always_comb
    begin
        cand  = cmd.div_first ? {1'b0, num_reg} : {rem_reg, 1'b0};
        q_bit = (cand >= {1'b0, den_reg});
    end

    // remainder stays below den, so it fits PROD_W bits
    always_ff @(posedge clk)
    begin
        if (cmd.div_en)
        begin
            rem_reg <= q_bit ? PROD_W'(cand - {1'b0, den_reg}) : cand[PROD_W-1:0];
            quo_reg <= {quo_reg[RATIO_W-2:0], q_bit};
        end
    end

    // ---- output register ----
    logic               out_valid_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic               zden_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            ratio_reg <= (sat_reg || zero_reg) ? RATIO_MAX : quo_reg;
            zden_reg  <= zero_reg;
        end
    end

    assign status.out_busy  = out_valid_reg && !out_ready;
    assign out_valid        = out_valid_reg;
    assign overlap_ratio    = ratio_reg;
    assign zero_denominator = zden_reg;

endmodule

// File: rtl/mode_overlap_ratio.sv
`timescale 1ns / 1ps
// ============================================================================
// mode_overlap_ratio
// Overlap ratio |s12*s21| / |s11*s22| of two modes, one grid cell per item.
// ============================================================================
// Throughput: one cell item per cycle while accumulating.
// After the last-cell item is taken the sequencer runs drain, magnitude,
//   9 shared-multiplier steps, check, 16 divide steps and the result load,
//   which waits while out_busy; no item is taken in that window.
// The divide loop yields one quotient bit a cycle, and the half-width
//   multiplier makes 4 passes per product.
// Reset clears the sums, the sequencer and the output valid.
module mode_overlap_ratio
#(
    parameter int CELL_COUNT_LOG2 = mor_pkg::CELL_COUNT_LOG2_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [mor_pkg::FIELD_W-1:0] e_x_first,
    input  logic signed [mor_pkg::FIELD_W-1:0] e_y_first,
    input  logic signed [mor_pkg::FIELD_W-1:0] h_x_first,
    input  logic signed [mor_pkg::FIELD_W-1:0] h_y_first,
    input  logic signed [mor_pkg::FIELD_W-1:0] e_x_second,
    input  logic signed [mor_pkg::FIELD_W-1:0] e_y_second,
    input  logic signed [mor_pkg::FIELD_W-1:0] h_x_second,
    input  logic signed [mor_pkg::FIELD_W-1:0] h_y_second,
    input  logic                               last_cell,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mor_pkg::RATIO_W-1:0]        overlap_ratio,
    output logic                               zero_denominator
);
    import mor_pkg::*;

    mor_cmd_t    cmd;
    mor_status_t status;

    mor_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_cell (last_cell),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mor_datapath
    #(
        .CELL_COUNT_LOG2 (CELL_COUNT_LOG2)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .e_x_first        (e_x_first),
        .e_y_first        (e_y_first),
        .h_x_first        (h_x_first),
        .h_y_first        (h_y_first),
        .e_x_second       (e_x_second),
        .e_y_second       (e_y_second),
        .h_x_second       (h_x_second),
        .h_y_second       (h_y_second),
        .cmd              (cmd),
        .status           (status),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .overlap_ratio    (overlap_ratio),
        .zero_denominator (zero_denominator)
    );

endmodule
